### hw/rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg: shared constants and types for the LIS tail table
// Table depth, field widths and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int MAX_LEN = 1024;                 // tail cells in the chain
    localparam int VAL_W   = 32;                   // value field width
    localparam int LEN_W   = 11;                   // lis_length field width
    localparam int CNT_W   = $clog2(MAX_LEN + 1);  // holds 0..MAX_LEN
    localparam int LEN_MAX = (1 << LEN_W) - 1;     // field saturation point

    // One value on its way down the chain
    typedef struct packed {
        logic                    vld;     // token carries an accepted beat
        logic                    last;    // final element of its sequence
        logic                    placed;  // already written into some cell
        logic                    app;     // written into a free cell (append)
        logic signed [VAL_W-1:0] value;
    } lis_tok_t;

    // Clip a table length to the output field
    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+LEN_W-1:0] wide;
        wide = (CNT_W + LEN_W)'(cnt);
        if (wide > (CNT_W + LEN_W)'(LEN_MAX))
            return LEN_W'(LEN_MAX);
        else
            return wide[LEN_W-1:0];
    endfunction

endpackage

### hw/rtl/lis_in_if.sv
// ----------------------------------------------------------------------------
// lis_in_if: input channel of the LIS tail table
// One sequence element per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lis_in_if import lis_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface

### hw/rtl/lis_out_if.sv
// ----------------------------------------------------------------------------
// lis_out_if: result channel of the LIS tail table
// One length/overflow beat per finished sequence, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lis_out_if import lis_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] lis_length;
    logic             overflow;

    modport source (output valid, output lis_length, output overflow, input ready);
    modport sink   (input valid, input lis_length, input overflow, output ready);

endinterface

### hw/rtl/lis_cell.sv
// ----------------------------------------------------------------------------
// lis_cell: one tail slot of the chain
// Holds one tail and its occupancy flag; replaces or appends, then passes on.
// ----------------------------------------------------------------------------
module lis_cell import lis_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  lis_tok_t tok_in,
    output lis_tok_t tok_out
);

    logic                    occ_reg;
    logic                    occ_next;
    logic signed [VAL_W-1:0] tail_reg;
    logic signed [VAL_W-1:0] tail_next;
    lis_tok_t                tok_reg;
    lis_tok_t                tok_next;

    always_comb
    begin
        occ_next  = occ_reg;
        tail_next = tail_reg;
        tok_next  = tok_in;
        if (tok_in.vld && !tok_in.placed)
        begin
            if (!occ_reg)
            begin
                // first free slot: append
                tail_next       = tok_in.value;
                occ_next        = 1'b1;
                tok_next.placed = 1'b1;
                tok_next.app    = 1'b1;
            end
            else if (tail_reg >= tok_in.value)
            begin
                // lower bound hit: replace
                tail_next       = tok_in.value;
                tok_next.placed = 1'b1;
            end
        end
        // end of sequence empties the slot behind the beat
        if (tok_in.vld && tok_in.last)
            occ_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (en)
        begin
            occ_reg <= occ_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tail_reg <= tail_next;
    end

    assign tok_out = tok_reg;

endmodule

### hw/rtl/lis_tally.sv
// ----------------------------------------------------------------------------
// lis_tally: chain end, length count and result register
// Counts appends, tracks overflow, presents the result beat, drives stall.
// ----------------------------------------------------------------------------
module lis_tally import lis_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  lis_tok_t  tok,
    output logic      en,
    lis_out_if.source result
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_sum;
    logic             ovf_reg;
    logic             ovf_next;
    logic             ovf_seq;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic [LEN_W-1:0] out_len_reg;
    logic [LEN_W-1:0] out_len_next;
    logic             out_ovf_reg;
    logic             out_ovf_next;
    logic             take;

    // chain advances unless a result beat is stuck
    assign en   = !out_vld_reg || result.ready;
    assign take = en && tok.vld;

    always_comb
    begin
        cnt_sum      = cnt_reg + CNT_W'(tok.app);
        ovf_seq      = ovf_reg | !tok.placed;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        out_vld_next = out_vld_reg;
        out_len_next = out_len_reg;
        out_ovf_next = out_ovf_reg;
        if (result.ready)
            out_vld_next = 1'b0;
        if (take)
        begin
            if (tok.last)
            begin
                cnt_next     = '0;
                ovf_next     = 1'b0;
                out_vld_next = 1'b1;
                out_len_next = sat_len(cnt_sum);
                out_ovf_next = ovf_seq;
            end
            else
            begin
                cnt_next = cnt_sum;
                ovf_next = ovf_seq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign result.valid      = out_vld_reg;
    assign result.lis_length = out_len_reg;
    assign result.overflow   = out_ovf_reg;

    // count never passes the number of cells
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEN))
        else $error("tail count beyond table depth");

    // an append only lands while a slot is free
    a_app_free: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.vld && tok.app) |-> (cnt_reg < CNT_W'(MAX_LEN)))
        else $error("append seen with full table");

    // a value falls off the end only when every slot is taken
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.vld && !tok.placed) |-> (cnt_reg == CNT_W'(MAX_LEN)))
        else $error("value dropped with free slots");

    // end of sequence restarts the count
    a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && tok.last) |=> (cnt_reg == '0 && !ovf_reg && out_vld_reg))
        else $error("sequence end did not clear state");

endmodule

### hw/rtl/lis_length_tail_table.sv
// A last_item token passes every cell register, then the result register.
// Throughput: one beat per cycle; each beat walks the MAX_LEN-cell tail chain.
// The chain stalls as a whole only while a result beat waits on result.ready.
// Reset clears every occupancy flag, the length count and the overflow flag;
// tail values are not reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
// lis_length_tail_table: longest strictly increasing subsequence length
// Patience-sort tail table built as a systolic chain of tail cells.
// ----------------------------------------------------------------------------
module lis_length_tail_table import lis_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lis_in_if.sink    feed,
    lis_out_if.source result
);

    // Each cell holds one tail (sorted ascending along the chain) and an
    // occupancy flag; the occupied cells always form a prefix.  A beat enters
    // cell 0 as a token and moves one cell per cycle unless the chain
    // stalls.  The first occupied cell whose tail is not less than the
    // value takes it (lower bound); failing that, the first free cell
    // takes it (append).  A token that leaves the chain unplaced met a
    // full table: overflow.
    // Beats keep at least one cell apart, so every cell sees the beats
    // of a stream in arrival order - the table each beat meets is exactly
    // the one its predecessors left.  The last beat of a sequence empties
    // each cell behind it, so the next sequence starts on a clean table.
    //
    // Length is counted at the far end from the append marks of the tokens.

    lis_tok_t tok [0:MAX_LEN];
    lis_tok_t head_tok;
    logic     en;

    assign feed.ready = en;

    // token for the beat entering cell 0
    always_comb
    begin
        head_tok        = '0;
        head_tok.vld    = feed.valid && en;
        head_tok.last   = feed.last_item;
        head_tok.value  = feed.value;
    end

    assign tok[0] = head_tok;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        lis_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // end of chain: counting, overflow tracking and the result beat
    lis_tally u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok    (tok[MAX_LEN]),
        .en     (en),
        .result (result)
    );

endmodule

### dv/lis_length_tail_table_tb.sv
// ----------------------------------------------------------------------------
// lis_length_tail_table_tb: self-checking bench for the LIS tail table
// Streams signed sequences into the chain under bursty input and a stalling
// result side, predicts each sequence's LIS length and overflow flag with a
// local tail table, and checks every result beat in order.
// ----------------------------------------------------------------------------
module lis_length_tail_table_tb;
    import lis_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fff_ffff;

    // One input beat waiting to go out; drain holds it back until all
    // outstanding results have been seen.
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    drain;
    } lis_beat_t;

    // What one finished sequence should report
    typedef struct {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } lis_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lis_in_if  feed_ch ();
    lis_out_if result_ch ();

    lis_length_tail_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Local tail table: tail_min[k] is the smallest end of any strictly
    // increasing run of length k+1 seen so far in the current sequence.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] tail_min [MAX_LEN];
    int                      tail_cnt = 0;
    logic                    ovf_seen = 1'b0;

    lis_beat_t   beat_q [$];
    lis_result_t lis_expected [$];

    int beat_total = 0;
    int beats_in = 0;
    int seq_total = 0;
    int results_seen = 0;
    int ovf_results = 0;
    int longest = 0;
    int mismatches = 0;
    int cycles = 0;

    // Fold one accepted beat into the tail table; on the last beat of a
    // sequence queue the expected result and start afresh.
    task automatic lis_absorb(input logic signed [VAL_W-1:0] v, input logic last);
        int lo;
        int hi;
        int mid;
        lis_result_t r;
        if (tail_cnt == 0 || v > tail_min[tail_cnt-1]) begin
            // append, or drop and flag when the table is already full
            if (tail_cnt < MAX_LEN) begin
                tail_min[tail_cnt] = v;
                tail_cnt++;
            end
            else
                ovf_seen = 1'b1;
        end
        else begin
            // lower bound: first tail not less than v (always exists here)
            lo = 0;
            hi = tail_cnt;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (tail_min[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            tail_min[lo] = v;
        end
        if (last) begin
            r.len = (tail_cnt > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(tail_cnt);
            r.ovf = ovf_seen;
            lis_expected.insert(lis_expected.size(), r);
            tail_cnt = 0;
            ovf_seen = 1'b0;
        end
    endtask

    task automatic push_beat(input logic signed [VAL_W-1:0] v, input logic last,
                             input logic drain);
        lis_beat_t b;
        b.value = v;
        b.last  = last;
        b.drain = drain;
        beat_q.insert(beat_q.size(), b);
        if (last)
            seq_total++;
    endtask

    // Random element in one of several flavours: a narrow band around zero
    // (lots of repeats), the full range, hugging the extremes, or a rising
    // ramp with jitter so runs get long.
    function automatic logic signed [VAL_W-1:0] pick_value(input int style, input int idx,
                                                          input int base);
        case (style)
            0: return VAL_W'(int'($urandom_range(0, 12)) - 6);
            1: return VAL_W'($urandom);
            2:
            begin
                if ($urandom_range(0, 1) == 1)
                    return VMIN + VAL_W'($urandom_range(0, 3));
                else
                    return VMAX - VAL_W'($urandom_range(0, 3));
            end
            default: return VAL_W'(base + idx * 4 + int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the head of beat_q, holds it until accepted, and
    // idles in random gaps between bursts of random length.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_ch.valid     <= 1'b0;
            feed_ch.value     <= '0;
            feed_ch.last_item <= 1'b0;
        end
        else
        begin
            if (feed_ch.valid && feed_ch.ready)
            begin
                lis_absorb(feed_ch.value, feed_ch.last_item);
                void'(beat_q.pop_front());
                beats_in++;
            end
            // a beat on offer but not taken stays exactly as it is
            if (!(feed_ch.valid && !feed_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    feed_ch.valid <= 1'b0;
                end
                else if (beat_q.size() != 0 &&
                         !(beat_q[0].drain && lis_expected.size() != 0))
                begin
                    feed_ch.valid     <= 1'b1;
                    feed_ch.value     <= beat_q[0].value;
                    feed_ch.last_item <= beat_q[0].last;
                    if (burst_left <= 1)
                    begin
                        // occasional long burst, else short ones; gaps often none
                        burst_left = ($urandom_range(0, 4) == 0) ?
                                     $urandom_range(40, 200) : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    feed_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready follows a rotating 16-bit pattern, re-rolled each time
    // pat_age wraps; a quarter of the time the pattern is all ones. Bit 0 is
    // forced so every pattern holds at least one ready bit.
    // ------------------------------------------------------------------
    logic [15:0] stall_pat;
    int          pat_age;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_pat       <= 16'hffff;
            pat_age         <= 0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (pat_age == 63)
            begin
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff :
                             (16'($urandom) | 16'h0001);
                pat_age   <= 0;
            end
            else
            begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
                pat_age   <= pat_age + 1;
            end
            result_ch.ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lis_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (result_ch.overflow === 1'b1)
                ovf_results++;
            if (int'(result_ch.lis_length) > longest)
                longest = int'(result_ch.lis_length);
            if (lis_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: lis_length=%0d overflow=%b",
                             result_ch.lis_length, result_ch.overflow);
            end
            else
            begin
                want = lis_expected.pop_front();
                if (result_ch.lis_length !== want.len || result_ch.overflow !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: lis_length exp %0d got %0d, overflow exp %b got %b",
                                 results_seen, want.len, result_ch.lis_length,
                                 want.ovf, result_ch.overflow);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d beats taken, %0d results pending",
                     cycles, beats_in, beat_total, lis_expected.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        int seq_len;
        int style;
        int base;
        int rand_beats;
        logic drain;

        // --- directed ---
        // single-beat sequences at both ends of the range
        push_beat(VMIN, 1'b1, 1'b0);
        push_beat(VMAX, 1'b1, 1'b0);
        // extremes then replacements: length 2
        push_beat(VMIN, 1'b0, 1'b0);
        push_beat(VMAX, 1'b0, 1'b0);
        push_beat(0, 1'b0, 1'b0);
        push_beat(-1, 1'b1, 1'b0);
        // strictly falling: length 1
        push_beat(VMAX, 1'b0, 1'b0);
        push_beat(0, 1'b0, 1'b0);
        push_beat(VMIN, 1'b1, 1'b0);
        // repeats do not extend a strictly increasing run
        push_beat(5, 1'b0, 1'b0);
        push_beat(5, 1'b0, 1'b0);
        push_beat(5, 1'b1, 1'b0);
        // rising through zero: length 5
        for (k = -3; k <= 1; k++)
            push_beat(VAL_W'(k), k == 1, 1'b0);
        // replace the head, then grow past it: length 3
        push_beat(4, 1'b0, 1'b0);
        push_beat(1, 1'b0, 1'b0);
        push_beat(2, 1'b0, 1'b0);
        push_beat(3, 1'b1, 1'b0);

        // fill the table exactly, then two dropped appends, a replacement
        // while full, another append on a full table, closing on a
        // replacement; wait for everything before it
        for (k = 0; k < MAX_LEN + 2; k++)
            push_beat(VAL_W'(k * 5 - 2000), 1'b0, k == 0);
        push_beat(VMIN, 1'b0, 1'b0);
        push_beat(VMAX, 1'b0, 1'b0);
        push_beat(7, 1'b1, 1'b0);
        // flag must not leak into the next sequence
        push_beat(42, 1'b1, 1'b1);

        // --- random sequences ---
        rand_beats = 0;
        while (rand_beats < 650)
        begin
            k = $urandom_range(0, 99);
            if (k < 80)
                seq_len = $urandom_range(1, 20);
            else if (k < 97)
                seq_len = $urandom_range(21, 80);
            else
                seq_len = $urandom_range(200, 400);
            style = $urandom_range(0, 3);
            base  = int'($urandom_range(0, 2000)) - 1000;
            drain = ($urandom_range(0, 19) == 0);
            for (k = 0; k < seq_len; k++)
            begin
                // a sprinkle of full-range values inside any flavour
                if ($urandom_range(0, 9) == 0)
                    push_beat(pick_value(1, k, base), k == seq_len - 1, drain && k == 0);
                else
                    push_beat(pick_value(style, k, base), k == seq_len - 1, drain && k == 0);
            end
            rand_beats += seq_len;
        end
        beat_total = beat_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (beats_in == beat_total && lis_expected.size() == 0);
        // let any stray result beat fall out of the chain
        repeat (MAX_LEN + 32) @(posedge clk);

        $display("%0d sequences in %0d beats, %0d results checked", seq_total, beat_total,
                 results_seen);
        $display("%0d results flagged overflow, longest length reported %0d", ovf_results,
                 longest);
        if (mismatches == 0 && lis_expected.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     lis_expected.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
